FILE: src/assert_macros.svh
// Assertion macros shared by the trimmed-mean filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TMF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmf assertion failed");

`endif

FILE: src/tmf_pkg.sv
// Package of types and constants for the trimmed-mean sample filter.
package tmf_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int MAX_WINDOW   = 64;
  localparam int CFG_WIN_W    = 7;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 7;
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W        = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int DIV_W        = $clog2(MAX_WINDOW - 1);
  localparam int STEP_W       = $clog2(SUM_W);
  localparam int MIN_WINDOW   = 3;
  localparam int WINDOW_RESET = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_MODE = CFG_IDX_W'(1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_TRIM,
    ST_DIV,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic load_sample;
    logic update;
    logic trim;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic run_full;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: src/tmf_ifs.sv
// Stream and configuration channel interfaces of the trimmed-mean filter.
interface tmf_in_if;
  logic             valid;
  logic             ready;
  tmf_pkg::sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tmf_out_if;
  logic             valid;
  logic             ready;
  tmf_pkg::sample_t filtered;
  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

interface tmf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tmf_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [tmf_pkg::CFG_DATA_W-1:0]   wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: src/tmf_ctrl.sv
// Controller state machine of the trimmed-mean filter.
`include "assert_macros.svh"

module tmf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmf_pkg::dp_status_t status,
  output tmf_pkg::dp_cmd_t    cmd
);

  tmf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tmf_pkg::ST_UPDATE;
      end
      tmf_pkg::ST_UPDATE: begin
        state_nxt = status.run_full ? tmf_pkg::ST_TRIM : tmf_pkg::ST_IDLE;
      end
      tmf_pkg::ST_TRIM: begin
        state_nxt = tmf_pkg::ST_DIV;
      end
      tmf_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = tmf_pkg::ST_WAIT;
      end
      tmf_pkg::ST_WAIT: begin
        if (!status.out_busy) state_nxt = tmf_pkg::ST_IDLE;
      end
      default: state_nxt = tmf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tmf_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_sample = in_valid;
      end
      tmf_pkg::ST_UPDATE: cmd.update   = 1'b1;
      tmf_pkg::ST_TRIM:   cmd.trim     = 1'b1;
      tmf_pkg::ST_DIV:    cmd.div_step = 1'b1;
      tmf_pkg::ST_WAIT:   cmd.out_load = !status.out_busy;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  `TMF_ASSERT_NXT(a_accept_to_update, clk, rst_n, in_valid && in_ready,
                  state_r == tmf_pkg::ST_UPDATE)
  `TMF_ASSERT_NXT(a_trim_to_div, clk, rst_n, state_r == tmf_pkg::ST_TRIM,
                  state_r == tmf_pkg::ST_DIV)
  `TMF_ASSERT_NXT(a_load_to_idle, clk, rst_n, cmd.out_load,
                  state_r == tmf_pkg::ST_IDLE)

endmodule

FILE: src/tmf_dp.sv
// Datapath of the trimmed-mean filter: config, median, run stats, serial divider, output.
`include "assert_macros.svh"

module tmf_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tmf_pkg::dp_cmd_t                   cmd,
  output tmf_pkg::dp_status_t                status,
  input  tmf_pkg::sample_t                   in_sample,
  input  logic                               cfg_write,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tmf_pkg::sample_t                   out_filtered
);

  // configuration
  logic [tmf_pkg::CFG_WIN_W-1:0] window_len_r;
  logic                          median_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= tmf_pkg::CFG_WIN_W'(tmf_pkg::WINDOW_RESET);
      median_mode_r <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tmf_pkg::CFG_WINDOW_LEN:  window_len_r  <= cfg_wdata[tmf_pkg::CFG_WIN_W-1:0];
        tmf_pkg::CFG_MEDIAN_MODE: median_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sample capture and median grouping
  tmf_pkg::sample_t sample_r;
  tmf_pkg::sample_t hold0_r, hold1_r;
  logic [1:0]       phase_r;

  always_ff @(posedge clk) begin
    if (cmd.load_sample) sample_r <= in_sample;
  end

  tmf_pkg::sample_t lo, hi, med, val;
  logic             counted;

  always_comb begin
    lo = (hold0_r > hold1_r) ? hold1_r : hold0_r;
    hi = (hold0_r > hold1_r) ? hold0_r : hold1_r;
    if (sample_r > hi)      med = hi;
    else if (sample_r > lo) med = sample_r;
    else                    med = lo;
    val     = median_mode_r ? med : sample_r;
    counted = !median_mode_r || (phase_r == 2'd2) || (phase_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold0_r <= '0;
      hold1_r <= '0;
      phase_r <= '0;
    end else if (cmd.update) begin
      if (counted) begin
        phase_r <= '0;
      end else begin
        if (phase_r[0]) hold1_r <= sample_r;
        else            hold0_r <= sample_r;
        phase_r <= phase_r + 2'd1;
      end
    end
  end

  // running statistics
  tmf_pkg::sample_t             run_max_r, run_min_r;
  logic [tmf_pkg::SUM_W-1:0]    run_sum_r;
  logic [tmf_pkg::CNT_W-1:0]    run_count_r;
  logic [tmf_pkg::CNT_W-1:0]    count_nxt;
  logic [tmf_pkg::CNT_W-1:0]    eff_window;

  always_comb begin
    if (window_len_r < tmf_pkg::CFG_WIN_W'(tmf_pkg::MIN_WINDOW))
      eff_window = tmf_pkg::CNT_W'(tmf_pkg::MIN_WINDOW);
    else if (window_len_r > tmf_pkg::CFG_WIN_W'(tmf_pkg::MAX_WINDOW))
      eff_window = tmf_pkg::CNT_W'(tmf_pkg::MAX_WINDOW);
    else
      eff_window = tmf_pkg::CNT_W'(window_len_r);
    count_nxt = run_count_r + tmf_pkg::CNT_W'(1);
  end

  assign status.run_full = counted && (count_nxt >= eff_window);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r   <= '0;
      run_min_r   <= '0;
      run_sum_r   <= '0;
      run_count_r <= '0;
    end else if (cmd.trim) begin
      run_max_r   <= '0;
      run_min_r   <= '0;
      run_sum_r   <= '0;
      run_count_r <= '0;
    end else if (cmd.update && counted) begin
      if (run_count_r == '0) begin
        run_max_r <= val;
        run_min_r <= val;
      end else begin
        if (val > run_max_r) run_max_r <= val;
        if (val < run_min_r) run_min_r <= val;
      end
      run_sum_r   <= run_sum_r + tmf_pkg::SUM_W'(val);
      run_count_r <= count_nxt;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [tmf_pkg::SUM_W-1:0]  quo_r;
  logic [tmf_pkg::DIV_W-1:0]  rem_r;
  logic [tmf_pkg::DIV_W-1:0]  divisor_r;
  logic [tmf_pkg::STEP_W-1:0] step_r;
  logic [tmf_pkg::DIV_W:0]    trial;
  logic                       trial_ok;

  assign trial    = {rem_r, quo_r[tmf_pkg::SUM_W-1]};
  assign trial_ok = trial >= {1'b0, divisor_r};
  assign status.div_last = (step_r == tmf_pkg::STEP_W'(tmf_pkg::SUM_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.trim) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + tmf_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      quo_r     <= run_sum_r - tmf_pkg::SUM_W'(run_max_r) - tmf_pkg::SUM_W'(run_min_r);
      rem_r     <= '0;
      divisor_r <= tmf_pkg::DIV_W'(run_count_r - tmf_pkg::CNT_W'(2));
    end else if (cmd.div_step) begin
      rem_r <= trial_ok ? tmf_pkg::DIV_W'(trial - {1'b0, divisor_r})
                        : trial[tmf_pkg::DIV_W-1:0];
      quo_r <= {quo_r[tmf_pkg::SUM_W-2:0], trial_ok};
    end
  end

  // output register
  logic             out_valid_r;
  tmf_pkg::sample_t out_data_r;

  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (|quo_r[tmf_pkg::SUM_W-1:tmf_pkg::SAMPLE_BITS]) ? '1
                    : quo_r[tmf_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

  `TMF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
                  run_count_r <= tmf_pkg::CNT_W'(tmf_pkg::MAX_WINDOW))
  `TMF_ASSERT_IMP(a_max_ge_min, clk, rst_n, 1'b1, run_max_r >= run_min_r)
  `TMF_ASSERT_NXT(a_trim_clears, clk, rst_n, cmd.trim,
                  (run_count_r == '0) && (step_r == '0))

endmodule

FILE: src/trimmed_mean_sample_filter_unit.sv
// Top level of the trimmed-mean sample filter: controller, datapath and channel wiring.
//
// Usage:
//   in_chan  - one 10-bit converter sample per beat (valid/ready).
//   out_chan - one 10-bit trimmed mean per beat: (sum - max - min) / (count - 2).
//   cfg_chan - register writes: index 0 window_len (7 bits), index 1 median_mode
//              (bit 0). Always ready; write only while the block is idle.
// Timing:
//   A sample that completes no window passes through capture and update before
//   the next beat is taken. A sample that completes a window passes through
//   capture, update, trim, the bit-serial divider (one quotient bit per cycle
//   over the 16-bit sum), then the load of the output register.
//   In median mode only every third sample feeds the window.
// Reset (rst_n low, synchronous): window_len returns to 11, median_mode to 0,
//   the run statistics and median group clear and out_chan goes invalid.
// Backpressure: the result waits in the output register while the receiver
//   stalls; new samples keep being taken meanwhile, and only a second finished
//   result holds in the divider until the register frees.
module trimmed_mean_sample_filter_unit (
  input  logic   clk,
  input  logic   rst_n,
  tmf_in_if.sink    in_chan,
  tmf_out_if.source out_chan,
  tmf_cfg_if.sink   cfg_chan
);

  tmf_pkg::dp_cmd_t    cmd;
  tmf_pkg::dp_status_t status;
  logic                in_ready;

  // config port never stalls
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;

  tmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tmf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_sample    (in_chan.sample),
    .cfg_write    (cfg_chan.valid),
    .cfg_index    (cfg_chan.reg_index),
    .cfg_wdata    (cfg_chan.wdata),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_filtered (out_chan.filtered)
  );

endmodule
